// File: sv/assert_macros.svh
// Assertion macros used by the GPIO port RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define GPIO_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define GPIO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GPIO_ASSERT(lbl, clk, rstn, prop, msg)
`define GPIO_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: sv/gpio_pkg.sv
// Types and constants shared by the GPIO port modules.
`default_nettype none

package gpio_pkg;

	localparam int DATA_W        = 32;
	localparam int PIN_COUNT_DEF = 32;

	typedef enum logic [1:0] {
		ACT_READ   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_SAMPLE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_DATA   = 3'd0,
		REG_DIR    = 3'd1,
		REG_ICR_LO = 3'd2,
		REG_ICR_HI = 3'd3,
		REG_MASK   = 3'd4,
		REG_STATUS = 3'd5,
		REG_EDGE   = 3'd6
	} reg_sel_t;

	typedef enum logic [1:0] {
		MODE_LOW     = 2'd0,
		MODE_HIGH    = 2'd1,
		MODE_RISING  = 2'd2,
		MODE_FALLING = 2'd3
	} irq_mode_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [2:0]        reg_select;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] pad_levels;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
		logic [DATA_W-1:0] pad_out;
		logic [DATA_W-1:0] pad_drive_enable;
	} rsp_t;

endpackage

`default_nettype wire

// File: sv/gpio_irq_detect.sv
// Per-pin interrupt condition detection for one pad sample.
`default_nettype none

module gpio_irq_detect #(
	parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
	input  wire logic [PIN_COUNT-1:0]   pads,
	input  wire logic [PIN_COUNT-1:0]   prev,
	input  wire logic [2*PIN_COUNT-1:0] cfg,
	input  wire logic [PIN_COUNT-1:0]   any_edge,
	output logic      [PIN_COUNT-1:0]   hit
);

	always_comb begin
		hit = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (any_edge[i]) begin
				hit[i] = pads[i] ^ prev[i];
			end else begin
				unique case (gpio_pkg::irq_mode_t'(cfg[2*i +: 2]))
					gpio_pkg::MODE_LOW:     hit[i] = !pads[i];
					gpio_pkg::MODE_HIGH:    hit[i] = pads[i];
					gpio_pkg::MODE_RISING:  hit[i] = pads[i] & !prev[i];
					gpio_pkg::MODE_FALLING: hit[i] = !pads[i] & prev[i];
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/gpio_regfile.sv
// GPIO register file: bus access, sample update and result formation.
`default_nettype none

module gpio_regfile #(
	parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           go,
	input  wire gpio_pkg::req_t req,
	output gpio_pkg::rsp_t      rsp
);

	localparam int DW = gpio_pkg::DATA_W;

	logic [PIN_COUNT-1:0]   data_q, dir_q, mask_q, status_q, edge_q, prev_q;
	logic [2*PIN_COUNT-1:0] cfg_q;
	logic [PIN_COUNT-1:0]   data_d, dir_d, mask_d, status_d, edge_d, prev_d;
	logic [2*PIN_COUNT-1:0] cfg_d;
	logic [2*DW-1:0]        cfg_ext, cfg_ext_d;
	logic [PIN_COUNT-1:0]   pads, wdata, hit, rb_data;
	logic [DW-1:0]          rdata;

	assign pads    = req.pad_levels[PIN_COUNT-1:0];
	assign wdata   = req.write_data[PIN_COUNT-1:0];
	assign cfg_ext = (2*DW)'(cfg_q);
	// output pins read back the driven level, input pins the pad
	assign rb_data = (data_q & dir_q) | (pads & ~dir_q);

	gpio_irq_detect #(
		.PIN_COUNT(PIN_COUNT)
	) u_detect (
		.pads     (pads),
		.prev     (prev_q),
		.cfg      (cfg_q),
		.any_edge (edge_q),
		.hit      (hit)
	);

	always_comb begin
		data_d    = data_q;
		dir_d     = dir_q;
		mask_d    = mask_q;
		status_d  = status_q;
		edge_d    = edge_q;
		prev_d    = prev_q;
		cfg_ext_d = cfg_ext;
		rdata     = '0;
		unique case (req.action)
			gpio_pkg::ACT_READ: begin
				unique case (req.reg_select)
					gpio_pkg::REG_DATA:   rdata = DW'(rb_data);
					gpio_pkg::REG_DIR:    rdata = DW'(dir_q);
					gpio_pkg::REG_ICR_LO: rdata = cfg_ext[DW-1:0];
					gpio_pkg::REG_ICR_HI: rdata = cfg_ext[2*DW-1:DW];
					gpio_pkg::REG_MASK:   rdata = DW'(mask_q);
					gpio_pkg::REG_STATUS: rdata = DW'(status_q);
					gpio_pkg::REG_EDGE:   rdata = DW'(edge_q);
					default:              rdata = '0;
				endcase
			end
			gpio_pkg::ACT_WRITE: begin
				unique case (req.reg_select)
					gpio_pkg::REG_DATA:   data_d = wdata;
					gpio_pkg::REG_DIR:    dir_d = wdata;
					gpio_pkg::REG_ICR_LO: cfg_ext_d[DW-1:0] = req.write_data;
					gpio_pkg::REG_ICR_HI: cfg_ext_d[2*DW-1:DW] = req.write_data;
					gpio_pkg::REG_MASK:   mask_d = wdata;
					gpio_pkg::REG_STATUS: status_d = status_q & ~wdata;
					gpio_pkg::REG_EDGE:   edge_d = wdata;
					default:              ;
				endcase
			end
			gpio_pkg::ACT_SAMPLE: begin
				status_d = status_q | hit;
				prev_d   = pads;
			end
			default: ;
		endcase
		// drop configuration pairs of pins that are not built
		cfg_d = cfg_ext_d[2*PIN_COUNT-1:0];
	end

	assign rsp.read_data        = rdata;
	assign rsp.irq              = |(status_d & mask_d);
	assign rsp.pad_out          = DW'(data_d);
	assign rsp.pad_drive_enable = DW'(dir_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q   <= '0;
			dir_q    <= '0;
			cfg_q    <= '0;
			mask_q   <= '0;
			status_q <= '0;
			edge_q   <= '0;
			prev_q   <= '0;
		end else if (go) begin
			data_q   <= data_d;
			dir_q    <= dir_d;
			cfg_q    <= cfg_d;
			mask_q   <= mask_d;
			status_q <= status_d;
			edge_q   <= edge_d;
			prev_q   <= prev_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/gpio_port_with_interrupts.sv
// An accepted item waits in the input stage; its result is then registered in the output register once that is free.
// Throughput: one item per cycle while the output is not stalled; the register file updates once per item.
// A stalled output holds one result while one more item waits in the input stage.
// Reset (arst_n low) clears the register file, pad history and both valid flags; payload registers are not reset.
// Pins at or above PIN_COUNT read as zero and never raise status.
`default_nettype none

`include "assert_macros.svh"

module gpio_port_with_interrupts #(
	parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// request channel: bus read, bus write or pad sample tick
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire gpio_pkg::req_t req,
	// response channel: one result item per request item
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output gpio_pkg::rsp_t      rsp
);

	// input stage
	logic           req_valid_s1;
	gpio_pkg::req_t req_s1;

	// output register
	logic           rsp_valid_q;
	gpio_pkg::rsp_t rsp_q;

	gpio_pkg::rsp_t result;
	logic           adv;

	// advance the input stage into the output register when the
	// output register is empty or being emptied in this cycle
	assign adv       = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || adv;

	gpio_regfile #(
		.PIN_COUNT(PIN_COUNT)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv),
		.req    (req_s1),
		.rsp    (result)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req_ready) begin
				req_valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: load on accept / advance, hold otherwise
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an empty output register never blocks the request side
	`GPIO_ASSERT(a_ready_when_empty, clk, arst_n, !rsp_valid_q |-> req_ready, "req_ready low with empty output")
	// a waiting item in the input stage is neither lost nor altered
	`GPIO_ASSERT(a_s1_hold, clk, arst_n, (req_valid_s1 && !adv) |=> (req_valid_s1 && $stable(req_s1)), "input stage item dropped")
	// every advance leaves a result in the output register
	`GPIO_ASSERT(a_adv_fills, clk, arst_n, adv |=> rsp_valid_q, "advanced item produced no result")
	// nothing advances out of an empty input stage
	`GPIO_ASSERT(a_adv_needs_item, clk, arst_n, !adv || req_valid_s1, "advance without item")

endmodule

`default_nettype wire

// File: test/gpio_port_with_interrupts_tb.sv
// Self-checking testbench for the 32-pin GPIO port with edge and level interrupts.
`default_nettype none

module gpio_port_with_interrupts_tb;

	localparam int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF;
	localparam logic [31:0] PIN_MASK = (PIN_COUNT >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << PIN_COUNT) - 32'd1);

	// action and register codes that the block leaves unused
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [2:0] REG_NONE = 3'd7;

	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	gpio_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	gpio_pkg::rsp_t rsp;

	gpio_port_with_interrupts #(.PIN_COUNT(PIN_COUNT)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow copy of the port: registers and the pad levels of the last tick
	// ---------------------------------------------------------------
	logic [31:0] shadow_data      = '0;
	logic [31:0] shadow_dir       = '0;
	logic [31:0] shadow_icr_lo    = '0;
	logic [31:0] shadow_icr_hi    = '0;
	logic [31:0] shadow_mask      = '0;
	logic [31:0] shadow_status    = '0;
	logic [31:0] shadow_any_edge  = '0;
	logic [31:0] shadow_prev_pads = '0;

	gpio_pkg::rsp_t expected_rsp[$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_ask       = 0;
	int unsigned hold_seen      = 0;
	int unsigned hold_left      = 0;

	int unsigned cycle_count     = 0;
	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count  = 0;
	int unsigned reads_seen      = 0;
	int unsigned writes_seen     = 0;
	int unsigned ticks_seen      = 0;
	int unsigned irq_results     = 0;

	logic [31:0] last_pads = '0;

	// Config bit pairs that belong to implemented pins, pins first..first+15.
	function automatic logic [31:0] cfg_pins(input int first);
		logic [31:0] m;
		m = '0;
		for (int k = 0; k < 16; k++) begin
			if (first + k < PIN_COUNT)
				m[2*k +: 2] = 2'b11;
		end
		return m;
	endfunction

	// Apply one item to the shadow registers and return the result it yields.
	// The result reflects the state after the item's own update.
	function automatic gpio_pkg::rsp_t predict_response(input gpio_pkg::req_t item);
		gpio_pkg::rsp_t      out;
		logic [31:0]         rise;
		logic [31:0]         fall;
		logic [31:0]         hits;
		gpio_pkg::irq_mode_t mode;
		out = '0;
		case (item.action)
			gpio_pkg::ACT_READ: begin
				case (item.reg_select)
					gpio_pkg::REG_DATA:   out.read_data = ((shadow_data & shadow_dir) |
						(item.pad_levels & ~shadow_dir)) & PIN_MASK;
					gpio_pkg::REG_DIR:    out.read_data = shadow_dir;
					gpio_pkg::REG_ICR_LO: out.read_data = shadow_icr_lo;
					gpio_pkg::REG_ICR_HI: out.read_data = shadow_icr_hi;
					gpio_pkg::REG_MASK:   out.read_data = shadow_mask;
					gpio_pkg::REG_STATUS: out.read_data = shadow_status;
					gpio_pkg::REG_EDGE:   out.read_data = shadow_any_edge;
					default:              out.read_data = '0;
				endcase
			end
			gpio_pkg::ACT_WRITE: begin
				case (item.reg_select)
					gpio_pkg::REG_DATA:   shadow_data   = item.write_data & PIN_MASK;
					gpio_pkg::REG_DIR:    shadow_dir    = item.write_data & PIN_MASK;
					gpio_pkg::REG_ICR_LO: shadow_icr_lo = item.write_data & cfg_pins(0);
					gpio_pkg::REG_ICR_HI: shadow_icr_hi = item.write_data & cfg_pins(16);
					gpio_pkg::REG_MASK:   shadow_mask   = item.write_data & PIN_MASK;
					gpio_pkg::REG_STATUS: shadow_status = shadow_status & ~item.write_data;
					gpio_pkg::REG_EDGE:   shadow_any_edge = item.write_data & PIN_MASK;
					default: ;
				endcase
			end
			gpio_pkg::ACT_SAMPLE: begin
				rise = item.pad_levels & ~shadow_prev_pads;
				fall = ~item.pad_levels & shadow_prev_pads;
				hits = '0;
				for (int i = 0; i < PIN_COUNT; i++) begin
					mode = (i < 16) ? gpio_pkg::irq_mode_t'(shadow_icr_lo[2*i +: 2]) :
						gpio_pkg::irq_mode_t'(shadow_icr_hi[2*(i-16) +: 2]);
					if (shadow_any_edge[i])
						hits[i] = rise[i] | fall[i];
					else begin
						case (mode)
							gpio_pkg::MODE_LOW:    hits[i] = ~item.pad_levels[i];
							gpio_pkg::MODE_HIGH:   hits[i] = item.pad_levels[i];
							gpio_pkg::MODE_RISING: hits[i] = rise[i];
							default:               hits[i] = fall[i];
						endcase
					end
				end
				shadow_status    = shadow_status | hits;
				shadow_prev_pads = item.pad_levels & PIN_MASK;
			end
			default: ;
		endcase
		out.irq              = |(shadow_status & shadow_mask);
		out.pad_out          = shadow_data;
		out.pad_drive_enable = shadow_dir;
		return out;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					results_checked, field, want, got);
		end
	endtask

	// ---------------------------------------------------------------
	// Monitor: predict on each accepted request item, then check each
	// accepted result item against the oldest prediction. Both are done in
	// one process so the order within an edge is fixed.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		gpio_pkg::rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			case (req.action)
				gpio_pkg::ACT_READ:   reads_seen++;
				gpio_pkg::ACT_WRITE:  writes_seen++;
				gpio_pkg::ACT_SAMPLE: ticks_seen++;
				default: ;
			endcase
			expected_rsp.push_back(predict_response(req));
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result item with nothing expected: %h", rsp);
			end else begin
				want = expected_rsp.pop_front();
				check_field("read_data", want.read_data, rsp.read_data);
				check_field("irq", 32'(want.irq), 32'(rsp.irq));
				check_field("pad_out", want.pad_out, rsp.pad_out);
				check_field("pad_drive_enable", want.pad_drive_enable,
					rsp.pad_drive_enable);
				if (want.irq)
					irq_results++;
			end
			results_checked++;
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sender: idle at random, then offer one item and hold it until taken.
	// Leave valid high on return so back-to-back items need no toggle.
	// ---------------------------------------------------------------
	task automatic send_item(input gpio_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic do_read(input logic [2:0] sel, input logic [31:0] pads);
		gpio_pkg::req_t item;
		item = '0;
		item.action     = gpio_pkg::ACT_READ;
		item.reg_select = sel;
		item.write_data = $urandom;
		item.pad_levels = pads;
		send_item(item);
	endtask

	task automatic do_write(input logic [2:0] sel, input logic [31:0] value);
		gpio_pkg::req_t item;
		item = '0;
		item.action     = gpio_pkg::ACT_WRITE;
		item.reg_select = sel;
		item.write_data = value;
		item.pad_levels = $urandom;
		send_item(item);
	endtask

	task automatic do_tick(input logic [31:0] pads);
		gpio_pkg::req_t item;
		item = '0;
		item.action     = gpio_pkg::ACT_SAMPLE;
		item.reg_select = 3'($urandom_range(7));
		item.write_data = $urandom;
		item.pad_levels = pads;
		send_item(item);
	endtask

	// Random item; pads most often flip one pin, else they hold, invert or take random levels.
	function automatic gpio_pkg::req_t random_request();
		gpio_pkg::req_t item;
		int unsigned    pick;
		pick = $urandom_range(99);
		if (pick < 30)
			item.action = gpio_pkg::ACT_READ;
		else if (pick < 62)
			item.action = gpio_pkg::ACT_WRITE;
		else if (pick < 96)
			item.action = gpio_pkg::ACT_SAMPLE;
		else
			item.action = ACT_NONE;
		item.reg_select = 3'($urandom_range(7));
		case ($urandom_range(4))
			0:       item.write_data = 32'hFFFF_FFFF;
			1:       item.write_data = '0;
			2:       item.write_data = 32'd1 << $urandom_range(31);
			default: item.write_data = $urandom;
		endcase
		case ($urandom_range(4))
			0:       last_pads = $urandom;
			1:       last_pads = ~last_pads;
			2:       last_pads = last_pads;
			default: last_pads = last_pads ^ (32'd1 << $urandom_range(31));
		endcase
		item.pad_levels = last_pads;
		return item;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Read back reset state: all pins are inputs, so data shows the pads.
	task automatic test_idle_reads();
		do_read(gpio_pkg::REG_DATA, 32'hFFFF_FFFF);
		do_read(gpio_pkg::REG_EDGE, 32'h0);
	endtask

	// Walk every interrupt mode; the first tick must come first in the run.
	task automatic test_interrupt_modes();
		do_write(gpio_pkg::REG_ICR_LO, 32'hAAAA_AAAA);  // rising on pins 0..15
		do_write(gpio_pkg::REG_ICR_HI, 32'hFFFF_FFFF);  // falling on pins 16..31
		do_write(gpio_pkg::REG_MASK, 32'hFFFF_FFFF);
		do_tick(32'hFFFF_FFFF);               // first tick: high pads are rising edges
		do_read(gpio_pkg::REG_STATUS, 32'h0);
		do_write(gpio_pkg::REG_STATUS, 32'h0000_FFFF);  // clear the rising flags
		do_tick(32'h0);                       // upper pins fall
		do_write(gpio_pkg::REG_ICR_LO, 32'h5555_5555);  // high level
		do_write(gpio_pkg::REG_ICR_HI, 32'h0);          // low level
		do_write(gpio_pkg::REG_STATUS, 32'hFFFF_FFFF);
		do_tick(32'h0000_FFFF);
		do_write(gpio_pkg::REG_STATUS, 32'hFFFF_FFFF);
		do_tick(32'h0000_FFFF);               // levels hold, so flags come back
		do_write(gpio_pkg::REG_EDGE, 32'hFFFF_FFFF);    // any edge overrides the modes
		do_write(gpio_pkg::REG_STATUS, 32'hFFFF_FFFF);
		do_tick(32'hFFFF_0000);
		do_read(gpio_pkg::REG_STATUS, 32'h0);
		do_write(gpio_pkg::REG_MASK, 32'h0);            // masked flags drop irq
	endtask

	// Mixed directions: data reads the driven bit on outputs, pads on inputs.
	task automatic test_port_io();
		do_write(gpio_pkg::REG_DIR, 32'hFFFF_0000);
		do_write(gpio_pkg::REG_DATA, 32'hA5A5_A5A5);
		do_read(gpio_pkg::REG_DATA, 32'h5A5A_5A5A);
		do_read(gpio_pkg::REG_DIR, 32'h0);
	endtask

	// Unused register number and unused action change nothing.
	task automatic test_unused_codes();
		gpio_pkg::req_t item;
		do_write(REG_NONE, 32'hFFFF_FFFF);
		do_read(REG_NONE, 32'hFFFF_FFFF);
		item = '0;
		item.action     = ACT_NONE;
		item.reg_select = gpio_pkg::REG_DATA;
		item.write_data = 32'hFFFF_FFFF;
		item.pad_levels = 32'hFFFF_FFFF;
		send_item(item);
	endtask

	task automatic test_random_traffic(input int count, input int unsigned send_pct,
			input int unsigned recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count)
			send_item(random_request());
	endtask

	// Hold the receiver off while the sender keeps offering items, so the
	// block fills and stalls its input; release drains the backlog.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_ask++;
		repeat (40)
			send_item(random_request());
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_reads();
		test_interrupt_modes();
		test_port_io();
		test_unused_codes();

		test_random_traffic(145, 0, 0);
		test_random_traffic(145, 65, 0);
		test_random_traffic(145, 0, 65);
		test_backpressure();
		test_random_traffic(145, 22, 22);

		// Stop offering, open the receiver and let the pipeline empty.
		req_valid      <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d reads, %0d writes, %0d pad ticks, with stalls on both sides",
			items_sent, reads_seen, writes_seen, ticks_seen);
		$display("checked %0d results, %0d with irq raised, %0d mismatches",
			results_checked, irq_results, mismatch_count);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/gpio_pkg.sv
sv/gpio_irq_detect.sv
sv/gpio_regfile.sv
sv/gpio_port_with_interrupts.sv
test/gpio_port_with_interrupts_tb.sv
